/* src/bsp_pkg.sv */
package bsp_pkg;

  // Read targets
  localparam logic [3:0] RD_RAM      = 4'd0;
  localparam logic [3:0] RD_BASIC    = 4'd1;
  localparam logic [3:0] RD_KERNAL   = 4'd2;
  localparam logic [3:0] RD_CHAR     = 4'd3;
  localparam logic [3:0] RD_VIC      = 4'd4;
  localparam logic [3:0] RD_SID      = 4'd5;
  localparam logic [3:0] RD_COLOR    = 4'd6;
  localparam logic [3:0] RD_CIA1     = 4'd7;
  localparam logic [3:0] RD_CIA2     = 4'd8;
  localparam logic [3:0] RD_IO1      = 4'd9;
  localparam logic [3:0] RD_IO2      = 4'd10;
  localparam logic [3:0] RD_ROML     = 4'd11;
  localparam logic [3:0] RD_ROMH     = 4'd12;
  localparam logic [3:0] RD_UA0      = 4'd13;
  localparam logic [3:0] RD_UNMAPPED = 4'd14;

  // Write targets
  localparam logic [4:0] WR_RAM      = 5'd0;
  localparam logic [4:0] WR_VIC      = 5'd1;
  localparam logic [4:0] WR_SID      = 5'd2;
  localparam logic [4:0] WR_DEBUG    = 5'd3;
  localparam logic [4:0] WR_COLOR    = 5'd4;
  localparam logic [4:0] WR_CIA1     = 5'd5;
  localparam logic [4:0] WR_CIA2     = 5'd6;
  localparam logic [4:0] WR_IO1      = 5'd7;
  localparam logic [4:0] WR_IO2      = 5'd8;
  localparam logic [4:0] WR_UNMAPPED = 5'd9;
  localparam logic [4:0] WR_ROML     = 5'd10;
  localparam logic [4:0] WR_ROMH     = 5'd11;
  localparam logic [4:0] WR_UROML    = 5'd12;
  localparam logic [4:0] WR_UROMH    = 5'd13;
  localparam logic [4:0] WR_UA0      = 5'd14;
  localparam logic [4:0] WR_RAM80    = 5'd15;
  localparam logic [4:0] WR_RAMA0    = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] CFG_EXPANSION = 2'd0;
  localparam logic [1:0] CFG_DEBUG     = 2'd1;
  localparam logic [1:0] CFG_SPEED     = 2'd2;

  typedef struct packed {
    logic expansion_present;
    logic debug_register_enable;
    logic speed_hack;
  } cfg_t;

endpackage

/* src/bsp_decode.sv */
module bsp_decode (
  input  logic [7:0]    page,
  input  logic [4:0]    bank_bits,
  input  bsp_pkg::cfg_t cfg,
  output logic [3:0]    read_target,
  output logic [4:0]    write_target
);

  logic [1:0] rm;
  logic [1:0] cm;
  logic [2:0] sub;
  logic       ult;
  logic       hard_ult;
  logic [3:0] io_rd;
  logic [4:0] io_wr;

  assign rm       = bank_bits[1:0];
  assign cm       = bank_bits[4:3];
  assign sub      = bank_bits[2:0];
  assign ult      = (cm == 2'd2);
  assign hard_ult = ult && !cfg.speed_hack;

  // I/O area decode for pages d0-df.
  always_comb begin
    priority if (page < 8'hd4) begin
      io_rd = bsp_pkg::RD_VIC;
      io_wr = bsp_pkg::WR_VIC;
    end else if (page < 8'hd8) begin
      io_rd = bsp_pkg::RD_SID;
      io_wr = (page == 8'hd7 && cfg.debug_register_enable) ? bsp_pkg::WR_DEBUG
                                                            : bsp_pkg::WR_SID;
    end else if (page < 8'hdc) begin
      io_rd = bsp_pkg::RD_COLOR;
      io_wr = bsp_pkg::WR_COLOR;
    end else if (page == 8'hdc) begin
      io_rd = bsp_pkg::RD_CIA1;
      io_wr = bsp_pkg::WR_CIA1;
    end else if (page == 8'hdd) begin
      io_rd = bsp_pkg::RD_CIA2;
      io_wr = bsp_pkg::WR_CIA2;
    end else if (page == 8'hde) begin
      io_rd = bsp_pkg::RD_IO1;
      io_wr = bsp_pkg::WR_IO1;
    end else begin
      io_rd = bsp_pkg::RD_IO2;
      io_wr = bsp_pkg::WR_IO2;
    end
  end

  // Page map: the fixed map without a cartridge, the full map with one.
  always_comb begin
    read_target  = bsp_pkg::RD_RAM;
    write_target = bsp_pkg::WR_RAM;
    if (!cfg.expansion_present) begin
      priority if (page >= 8'ha0 && page < 8'hc0) begin
        if (rm == 2'd3) read_target = bsp_pkg::RD_BASIC;
      end else if (page >= 8'hd0 && page < 8'he0) begin
        priority if (rm == 2'd0) begin
          read_target = bsp_pkg::RD_RAM;
        end else if (!bank_bits[2]) begin
          read_target = bsp_pkg::RD_CHAR;
        end else begin
          read_target  = io_rd;
          write_target = io_wr;
        end
      end else if (page >= 8'he0) begin
        if (bank_bits[1]) read_target = bsp_pkg::RD_KERNAL;
      end
    end else begin
      priority if (page < 8'h10) begin
        read_target = bsp_pkg::RD_RAM;
      end else if (page < 8'h80 || (page >= 8'hc0 && page < 8'hd0)) begin
        if (hard_ult) begin
          read_target  = bsp_pkg::RD_UNMAPPED;
          write_target = bsp_pkg::WR_UNMAPPED;
        end
      end else if (page < 8'ha0) begin
        priority if (ult) begin
          read_target  = bsp_pkg::RD_ROML;
          write_target = bsp_pkg::WR_UROML;
        end else if (cm <= 2'd1 && rm == 2'd3) begin
          read_target  = bsp_pkg::RD_ROML;
          write_target = bsp_pkg::WR_ROML;
        end else begin
          write_target = bsp_pkg::WR_RAM80;
        end
      end else if (page < 8'hc0) begin
        priority if (ult) begin
          read_target  = bsp_pkg::RD_UA0;
          write_target = bsp_pkg::WR_UA0;
        end else if (cm[0] && rm == 2'd3) begin
          read_target  = bsp_pkg::RD_BASIC;
          write_target = bsp_pkg::WR_RAMA0;
        end else if (cm == 2'd0 && rm[1]) begin
          read_target  = bsp_pkg::RD_ROMH;
          write_target = bsp_pkg::WR_ROMH;
        end else begin
          write_target = bsp_pkg::WR_RAMA0;
        end
      end else if (page < 8'he0) begin
        priority if (hard_ult || sub >= 3'd5) begin
          read_target  = io_rd;
          write_target = io_wr;
        end else if (sub >= 3'd1 && sub <= 3'd3 && bank_bits != 5'd1) begin
          // LORAM alone with GAME and EXROM low leaves this area as RAM.
          read_target = bsp_pkg::RD_CHAR;
        end else begin
          read_target = bsp_pkg::RD_RAM;
        end
      end else begin
        priority if (ult) begin
          read_target  = bsp_pkg::RD_ROMH;
          write_target = bsp_pkg::WR_UROMH;
        end else if (rm[1]) begin
          read_target = bsp_pkg::RD_KERNAL;
        end else begin
          read_target = bsp_pkg::RD_RAM;
        end
      end
    end
  end

endmodule

/* src/bank_switch_page_decoder.sv */
// A word accepted is registered in the input register, then in the result register,
// and then presented on the output. Throughput: one word per cycle while out_stall
// is low; the two registers form a two-stage pipeline, so a word is taken while a
// result waits, as long as the input register is empty. Reset (rst, synchronous)
// empties both stages and clears the three configuration registers to zero.
module bank_switch_page_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_en,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] page,
  input  logic [4:0] bank_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] read_target,
  output logic [4:0] write_target
);

  bsp_pkg::cfg_t cfg;
  logic          s0_valid;
  logic [7:0]    s0_page;
  logic [4:0]    s0_bank;
  logic          s0_move;
  logic          in_take;
  logic [3:0]    dec_rd;
  logic [4:0]    dec_wr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        bsp_pkg::CFG_EXPANSION: cfg.expansion_present     <= cfg_data;
        bsp_pkg::CFG_DEBUG:     cfg.debug_register_enable <= cfg_data;
        bsp_pkg::CFG_SPEED:     cfg.speed_hack            <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign s0_move  = s0_valid && (!out_valid || !out_stall);
  assign in_stall = s0_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_take) begin
      s0_valid <= 1'b1;
    end else if (s0_move) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_page <= page;
      s0_bank <= bank_bits;
    end
  end

  bsp_decode u_decode (
    .page         (s0_page),
    .bank_bits    (s0_bank),
    .cfg          (cfg),
    .read_target  (dec_rd),
    .write_target (dec_wr)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s0_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move) begin
      read_target  <= dec_rd;
      write_target <= dec_wr;
    end
  end

  // The ultimax a0-bf window reads and writes through the same path.
  a_ua0_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_target == bsp_pkg::RD_UA0) |-> (write_target == bsp_pkg::WR_UA0))
    else $error("ultimax a0 read without matching write target");

  // The debug register only ever shadows a SID read.
  a_debug_sid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_target == bsp_pkg::WR_DEBUG) |-> (read_target == bsp_pkg::RD_SID))
    else $error("debug write target outside the SID area");

  // An empty input stage never holds off the source.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> !in_stall)
    else $error("input stalled while the input stage is empty");

  // A result held by a stall is still there in the next cycle.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_target) && $stable(write_target)))
    else $error("stalled result lost or changed");

endmodule
